/* rtl/core/crfr_pkg.sv */
`timescale 1ns / 1ps

package crfr_pkg;

  // Header layout, oldest byte first:
  //   type, address length, data length (LE16), data sum (LE32), header sum (LE32)
  localparam int HDR_BYTES     = 12;
  localparam int HDR_SUM_BYTES = 8;
  localparam int FILL_W        = $clog2(HDR_BYTES + 1);
  localparam int BYTE_W        = 8;
  localparam int LEN_W         = 16;
  localparam int IDX_W         = 17;
  localparam int SUM_W         = 32;
  localparam int HSUM_W        = BYTE_W + $clog2(HDR_SUM_BYTES);

  // Offsets of header fields within the window
  localparam int OFS_TYPE      = 0;
  localparam int OFS_ADDR_LEN  = 1;
  localparam int OFS_DATA_LEN  = 2;
  localparam int OFS_DATA_SUM  = 4;
  localparam int OFS_HDR_SUM   = 8;

  typedef logic [BYTE_W-1:0] byte_t;

  // Decoded view of the header window after the incoming word is shifted in
  typedef struct packed {
    logic              ok;
    logic [BYTE_W-1:0] ftype;
    logic [BYTE_W-1:0] addr_len;
    logic [LEN_W-1:0]  data_len;
    logic [SUM_W-1:0]  data_sum;
  } hdr_info_t;

endpackage

/* rtl/core/checksummed_frame_receiver_unit.sv */
`timescale 1ns / 1ps

// Checksummed frame receiver.
// Input channel (in_valid / in_stall / in_rx_byte) takes one link byte per word.
// While hunting, bytes slide through a 12-byte header window: type, address
// length, LE16 data length, LE32 data sum, LE32 header sum. A header is taken
// when the byte-sum of its first 8 bytes equals the header sum; hunting words
// produce no result.
// After a header, each body word (data bytes then address bytes) yields one
// result on the output channel with its index, the header fields, an is_last
// flag and, on the last word, frame_good (wrapping 32-bit body sum equals the
// header data sum). A header with zero body length yields one result with
// out_has_byte low on the word that completes the header.
// A word accepted from the input lands in the input register; its result is
// loaded into the output register when that word advances, which out_stall can
// delay. Throughput is one word per cycle while the output is not stalled, as
// the window check and the body counters update combinationally for each word.
// out_stall holds the output register; the input register then holds its
// word and in_stall rises only while both registers are occupied.
// Reset (rst_n low, synchronous) empties both registers and returns to
// hunting with an empty header window.

module checksummed_frame_receiver_unit (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            in_valid,
  output logic                            in_stall,
  input  logic [crfr_pkg::BYTE_W-1:0]     in_rx_byte,
  output logic                            out_valid,
  input  logic                            out_stall,
  output logic                            out_has_byte,
  output logic [crfr_pkg::BYTE_W-1:0]     out_payload_byte,
  output logic [crfr_pkg::IDX_W-1:0]      out_byte_index,
  output logic [crfr_pkg::BYTE_W-1:0]     out_frame_type,
  output logic [crfr_pkg::BYTE_W-1:0]     out_address_length,
  output logic [crfr_pkg::LEN_W-1:0]      out_data_length,
  output logic                            out_is_last,
  output logic                            out_frame_good
);

  // Input register
  logic                          in_valid_r;
  crfr_pkg::byte_t               in_byte_r;
  logic                          adv;

  // Frame state
  logic                          in_body_r, in_body_nxt;
  logic [crfr_pkg::IDX_W-1:0]    body_count_r, body_count_nxt;
  logic [crfr_pkg::IDX_W-1:0]    body_size_r, body_size_nxt;
  logic [crfr_pkg::SUM_W-1:0]    run_sum_r, run_sum_nxt;
  logic [crfr_pkg::SUM_W-1:0]    exp_sum_r, exp_sum_nxt;
  logic [crfr_pkg::BYTE_W-1:0]   type_r, type_nxt;
  logic [crfr_pkg::BYTE_W-1:0]   alen_r, alen_nxt;
  logic [crfr_pkg::LEN_W-1:0]    dlen_r, dlen_nxt;

  // Result register
  logic                          out_valid_r, out_valid_nxt;
  logic                          emit;
  logic                          res_has, res_last, res_good;
  crfr_pkg::byte_t               res_byte;
  logic [crfr_pkg::IDX_W-1:0]    res_idx;
  logic [crfr_pkg::BYTE_W-1:0]   res_type, res_alen;
  logic [crfr_pkg::LEN_W-1:0]    res_dlen;
  logic                          has_r, last_r, good_r;
  crfr_pkg::byte_t               byte_r;
  logic [crfr_pkg::IDX_W-1:0]    idx_r;
  logic [crfr_pkg::BYTE_W-1:0]   otype_r, oalen_r;
  logic [crfr_pkg::LEN_W-1:0]    odlen_r;

  crfr_pkg::hdr_info_t           hdr;
  logic [crfr_pkg::IDX_W-1:0]    hdr_size;
  logic [crfr_pkg::IDX_W-1:0]    count_inc;
  logic                          body_last;

  // Advance the held word whenever the result register is free or draining
  assign adv      = in_valid_r && (!out_valid_r || !out_stall);
  assign in_stall = in_valid_r && !adv;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_valid_r <= 1'b0;
    end else if (in_valid && !in_stall) begin
      in_valid_r <= 1'b1;
    end else if (adv) begin
      in_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && !in_stall) begin
      in_byte_r <= in_rx_byte;
    end
  end

  crfr_hdr_win u_hdr_win (
    .clk      (clk),
    .rst_n    (rst_n),
    .shift_en (adv && !in_body_r),
    .rx_byte  (in_byte_r),
    .hdr      (hdr)
  );

  assign hdr_size  = crfr_pkg::IDX_W'(hdr.data_len) + crfr_pkg::IDX_W'(hdr.addr_len);
  assign count_inc = body_count_r + 1'b1;
  assign body_last = (count_inc >= body_size_r);

  always_comb begin
    in_body_nxt    = in_body_r;
    body_count_nxt = body_count_r;
    body_size_nxt  = body_size_r;
    run_sum_nxt    = run_sum_r;
    exp_sum_nxt    = exp_sum_r;
    type_nxt       = type_r;
    alen_nxt       = alen_r;
    dlen_nxt       = dlen_r;
    emit           = 1'b0;
    res_has        = 1'b0;
    res_byte       = '0;
    res_idx        = '0;
    res_type       = type_r;
    res_alen       = alen_r;
    res_dlen       = dlen_r;
    res_last       = 1'b0;
    res_good       = 1'b0;
    if (adv) begin
      if (!in_body_r) begin
        if (hdr.ok) begin
          type_nxt       = hdr.ftype;
          alen_nxt       = hdr.addr_len;
          dlen_nxt       = hdr.data_len;
          exp_sum_nxt    = hdr.data_sum;
          body_size_nxt  = hdr_size;
          body_count_nxt = '0;
          run_sum_nxt    = '0;
          res_type       = hdr.ftype;
          res_alen       = hdr.addr_len;
          res_dlen       = hdr.data_len;
          if (hdr_size == '0) begin
            // Empty frame: close it on the header's final word
            emit     = 1'b1;
            res_last = 1'b1;
            res_good = (hdr.data_sum == '0);
          end else begin
            in_body_nxt = 1'b1;
          end
        end
      end else begin
        run_sum_nxt    = run_sum_r + crfr_pkg::SUM_W'(in_byte_r);
        body_count_nxt = count_inc;
        emit           = 1'b1;
        res_has        = 1'b1;
        res_byte       = in_byte_r;
        res_idx        = body_count_r;
        res_last       = body_last;
        res_good       = body_last && (run_sum_nxt == exp_sum_r);
        if (body_last) begin
          in_body_nxt = 1'b0;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_body_r <= 1'b0;
    end else begin
      in_body_r <= in_body_nxt;
    end
  end

  always_ff @(posedge clk) begin
    body_count_r <= body_count_nxt;
    body_size_r  <= body_size_nxt;
    run_sum_r    <= run_sum_nxt;
    exp_sum_r    <= exp_sum_nxt;
    type_r       <= type_nxt;
    alen_r       <= alen_nxt;
    dlen_r       <= dlen_nxt;
  end

  // Load a new result, drop a delivered one, otherwise hold
  always_comb begin
    out_valid_nxt = out_valid_r;
    if (out_valid_r && !out_stall) begin
      out_valid_nxt = 1'b0;
    end
    if (emit) begin
      out_valid_nxt = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (emit) begin
      has_r   <= res_has;
      byte_r  <= res_byte;
      idx_r   <= res_idx;
      otype_r <= res_type;
      oalen_r <= res_alen;
      odlen_r <= res_dlen;
      last_r  <= res_last;
      good_r  <= res_good;
    end
  end

  assign out_valid          = out_valid_r;
  assign out_has_byte       = has_r;
  assign out_payload_byte   = byte_r;
  assign out_byte_index     = idx_r;
  assign out_frame_type     = otype_r;
  assign out_address_length = oalen_r;
  assign out_data_length    = odlen_r;
  assign out_is_last        = last_r;
  assign out_frame_good     = good_r;

endmodule

/* rtl/core/crfr_hdr_win.sv */
`timescale 1ns / 1ps

module crfr_hdr_win (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  shift_en,
  input  crfr_pkg::byte_t       rx_byte,
  output crfr_pkg::hdr_info_t   hdr
);

  localparam int NB = crfr_pkg::HDR_BYTES;

  crfr_pkg::byte_t                win_r   [NB];
  crfr_pkg::byte_t                win_nxt [NB];
  logic [crfr_pkg::FILL_W-1:0]    fill_r;
  logic [crfr_pkg::FILL_W-1:0]    fill_nxt;
  logic                           full_after;
  logic [crfr_pkg::HSUM_W-1:0]    hsum;
  logic [crfr_pkg::SUM_W-1:0]     hdr_sum;

  // Newest word enters at the top; oldest sits at index zero once full
  always_comb begin
    for (int i = 0; i < NB - 1; i++) begin
      win_nxt[i] = win_r[i+1];
    end
    win_nxt[NB-1] = rx_byte;
  end

  assign full_after = (fill_r >= crfr_pkg::FILL_W'(NB - 1));

  always_comb begin
    hsum = '0;
    for (int i = 0; i < crfr_pkg::HDR_SUM_BYTES; i++) begin
      hsum = hsum + crfr_pkg::HSUM_W'(win_nxt[i]);
    end
  end

  assign hdr_sum = {win_nxt[crfr_pkg::OFS_HDR_SUM+3], win_nxt[crfr_pkg::OFS_HDR_SUM+2],
                    win_nxt[crfr_pkg::OFS_HDR_SUM+1], win_nxt[crfr_pkg::OFS_HDR_SUM]};

  assign hdr.ok       = full_after && (crfr_pkg::SUM_W'(hsum) == hdr_sum);
  assign hdr.ftype    = win_nxt[crfr_pkg::OFS_TYPE];
  assign hdr.addr_len = win_nxt[crfr_pkg::OFS_ADDR_LEN];
  assign hdr.data_len = {win_nxt[crfr_pkg::OFS_DATA_LEN+1], win_nxt[crfr_pkg::OFS_DATA_LEN]};
  assign hdr.data_sum = {win_nxt[crfr_pkg::OFS_DATA_SUM+3], win_nxt[crfr_pkg::OFS_DATA_SUM+2],
                         win_nxt[crfr_pkg::OFS_DATA_SUM+1], win_nxt[crfr_pkg::OFS_DATA_SUM]};

  // Restart the fill after a header is taken; saturate while sliding
  always_comb begin
    fill_nxt = fill_r;
    if (shift_en) begin
      if (hdr.ok) begin
        fill_nxt = '0;
      end else if (!full_after) begin
        fill_nxt = fill_r + 1'b1;
      end else begin
        fill_nxt = crfr_pkg::FILL_W'(NB);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      fill_r <= '0;
    end else begin
      fill_r <= fill_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (shift_en) begin
      win_r <= win_nxt;
    end
  end

endmodule
